// ===== hdl/mfr_pkg.sv =====
`default_nettype none

package mfr_pkg;

  localparam int unsigned CfgAddrW = 4;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned CountW   = 9;

  localparam logic [CfgAddrW-1:0] CfgDevAddr = CfgAddrW'(0);
  localparam logic [CfgAddrW-1:0] CfgLegacy  = CfgAddrW'(1);

  localparam logic [7:0]  DevAddrReset  = 8'h01;
  localparam logic [7:0]  LegacyCmd     = 8'h06;
  localparam logic [15:0] CrcPoly       = 16'hA001;
  localparam logic [15:0] CrcInit       = 16'hFFFF;
  localparam logic [8:0]  FrameOverhead = 9'd5;
  localparam logic [7:0]  LegacyPayload = 8'd3;

  typedef enum logic [1:0] {
    PhHunt = 2'd0,
    PhCmd  = 2'd1,
    PhLen  = 2'd2,
    PhBody = 2'd3
  } phase_e;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/mfr_if.sv =====
`default_nettype none

interface mfr_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] rx_byte;

  modport source (output valid, output cmd, output rx_byte, input ready);
  modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

interface mfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] echo_byte;
  logic [8:0] byte_index;
  logic       accepted;
  logic       frame_end;
  logic       crc_ok;

  modport source (output valid, output echo_byte, output byte_index, output accepted,
                  output frame_end, output crc_ok, input ready);
  modport sink   (input valid, input echo_byte, input byte_index, input accepted,
                  input frame_end, input crc_ok, output ready);
endinterface

interface mfr_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [mfr_pkg::CfgAddrW-1:0] addr;
  logic [mfr_pkg::CfgDataW-1:0] data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/modbus_frame_receiver_unit.sv =====
`default_nettype none

// Modbus RTU frame receiver. Each received byte word on in_i yields one status word on
// out_o (echo, position in frame, accepted, frame end, CRC match); an idle poll word
// sends the receiver back to address hunting and yields no status. The CRC-16
// (reflected 0xA001, start 0xFFFF) is checked against the last two frame bytes, low
// byte first. A status word passes the input register and then the output register,
// and one word is taken every cycle: the input register feeds a combinational update
// of the frame state (eight CRC bit steps in one pass) into the output register, so
// only downstream stalls slow the rate. Registers on cfg_i: 0 device address, 1 legacy
// command 6 payload; write them only while idle.
module modbus_frame_receiver_unit #(
  parameter int unsigned BufSize = 128
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  mfr_cfg_if.sink     cfg_i,
  mfr_in_if.sink      in_i,
  mfr_out_if.source   out_o
);
  import mfr_pkg::*;

  localparam logic [CountW-1:0] BufLimit = CountW'(BufSize);

  logic [7:0] dev_byte_q;
  logic       legacy_q;

  logic       s1_v_q;
  logic       s1_cmd_q;
  logic [7:0] s1_byte_q;

  phase_e      phase_q, phase_d, eff_phase;
  logic [8:0]  cnt_q, cnt_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [7:0]  len_q, len_d;
  logic [15:0] crc_q, crc_d, crc_fed;
  logic [15:0] held_q, held_d;

  logic       out_v_q;
  logic [7:0] o_echo_q, o_echo_d;
  logic [8:0] o_idx_q, o_idx_d;
  logic       o_acc_q, o_acc_d;
  logic       o_end_q, o_end_d;
  logic       o_ok_q, o_ok_d;

  logic       out_free, s1_adv, addr_hit, end_hit;
  logic [7:0] payload;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_byte_q <= DevAddrReset;
      legacy_q   <= 1'b0;
    end else if (cfg_i.valid) begin
      case (cfg_i.addr)
        CfgDevAddr: dev_byte_q <= cfg_i.data;
        CfgLegacy:  legacy_q   <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  assign out_free   = !out_v_q || out_o.ready;
  assign s1_adv     = s1_v_q && (s1_cmd_q || out_free);
  assign in_i.ready = !s1_v_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_cmd_q  <= in_i.cmd;
      s1_byte_q <= in_i.rx_byte;
    end
  end

  assign eff_phase = (cnt_q >= BufLimit) ? PhHunt : phase_q;
  assign addr_hit  = (s1_byte_q == dev_byte_q);
  assign payload   = (cmd_q == LegacyCmd && legacy_q) ? LegacyPayload : len_q;
  assign cnt_d     = (eff_phase == PhHunt) ? {8'h00, addr_hit} : cnt_q + 9'd1;
  assign end_hit   = (eff_phase == PhBody) && (cnt_d == {1'b0, payload} + FrameOverhead);

  always_comb begin
    phase_d = eff_phase;
    if (s1_cmd_q) begin
      phase_d = PhHunt;
    end else begin
      case (eff_phase)
        PhHunt:  phase_d = addr_hit ? PhCmd : PhHunt;
        PhCmd:   phase_d = PhLen;
        PhLen:   phase_d = PhBody;
        PhBody:  phase_d = end_hit ? PhHunt : PhBody;
        default: phase_d = PhHunt;
      endcase
    end
  end

  always_comb begin
    crc_fed  = (cnt_q >= 9'd2) ? crc_feed(crc_q, held_q[15:8]) : crc_q;
    crc_d    = crc_q;
    held_d   = held_q;
    cmd_d    = cmd_q;
    len_d    = len_q;
    o_echo_d = s1_byte_q;
    o_idx_d  = 9'd0;
    o_acc_d  = 1'b0;
    o_end_d  = 1'b0;
    o_ok_d   = 1'b0;
    if (eff_phase == PhHunt) begin
      if (addr_hit) begin
        o_acc_d = 1'b1;
        crc_d   = CrcInit;
        held_d  = {8'h00, s1_byte_q};
      end
    end else begin
      o_idx_d = cnt_q;
      o_acc_d = 1'b1;
      crc_d   = crc_fed;
      held_d  = {held_q[7:0], s1_byte_q};
      if (eff_phase == PhCmd) begin
        cmd_d = s1_byte_q;
      end
      if (eff_phase == PhLen) begin
        len_d = s1_byte_q;
      end
      if (end_hit) begin
        o_end_d = 1'b1;
        o_ok_d  = (held_q[7:0] == crc_fed[7:0]) && (s1_byte_q == crc_fed[15:8]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      cnt_q   <= 9'd0;
      cmd_q   <= 8'h00;
      len_q   <= 8'h00;
      crc_q   <= CrcInit;
      held_q  <= 16'h0000;
    end else if (s1_adv) begin
      phase_q <= phase_d;
      if (!s1_cmd_q) begin
        cnt_q  <= cnt_d;
        cmd_q  <= cmd_d;
        len_q  <= len_d;
        crc_q  <= crc_d;
        held_q <= held_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_free) begin
      out_v_q <= s1_adv && !s1_cmd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && !s1_cmd_q) begin
      o_echo_q <= o_echo_d;
      o_idx_q  <= o_idx_d;
      o_acc_q  <= o_acc_d;
      o_end_q  <= o_end_d;
      o_ok_q   <= o_ok_d;
    end
  end

  assign out_o.valid      = out_v_q;
  assign out_o.echo_byte  = o_echo_q;
  assign out_o.byte_index = o_idx_q;
  assign out_o.accepted   = o_acc_q;
  assign out_o.frame_end  = o_end_q;
  assign out_o.crc_ok     = o_ok_q;

`ifndef SYNTH
  a_end_accepted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && o_end_q |-> o_acc_q) else $error("frame end on a dropped byte");
  a_ok_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && o_ok_q |-> o_end_q) else $error("crc match outside frame end");
  a_idx_accepted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && (o_idx_q != 9'd0) |-> o_acc_q) else $error("index on a dropped byte");
  a_frame_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PhHunt |-> cnt_q != 9'd0) else $error("open frame with zero count");
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> s1_v_q && !s1_cmd_q && out_v_q) else $error("stall without full stage");
`endif

endmodule

`default_nettype wire

// ===== verif/modbus_frame_receiver_unit_check.sv =====
module modbus_frame_receiver_unit_check #(
  parameter int unsigned BufSize = 128
) (
  input  wire  clk_i,
  input  wire  rst_ni,
  mfr_cfg_if   cfg_mon,
  mfr_in_if    in_mon,
  mfr_out_if   out_mon,
  output int   fail_count_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import mfr_pkg::*;

  typedef struct packed {
    logic [7:0] echo;
    logic [8:0] index;
    logic       accepted;
    logic       frame_end;
    logic       crc_ok;
  } status_t;

  status_t     pending_status[$];

  logic [7:0]  dev_addr;
  logic        legacy;
  phase_e      phase;
  logic [8:0]  byte_cnt;
  logic [7:0]  cmd_byte;
  logic [7:0]  len_byte;
  logic [15:0] crc_acc;
  logic [15:0] held;

  function automatic logic [15:0] crc16_step(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {8'h00, b};
    repeat (8) c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    return c;
  endfunction

  task automatic track_rx_byte(input logic [7:0] b, output status_t s);
    logic [8:0] frame_len;
    s = '0;
    s.echo = b;
    if (byte_cnt >= BufSize) phase = PhHunt;
    if (phase == PhHunt) begin
      byte_cnt = '0;
      if (b == dev_addr) begin
        s.accepted = 1'b1;
        crc_acc    = CrcInit;
        held       = {8'h00, b};
        byte_cnt   = 9'd1;
        phase      = PhCmd;
      end
    end else begin
      s.index    = byte_cnt;
      s.accepted = 1'b1;
      if (byte_cnt >= 9'd2) crc_acc = crc16_step(crc_acc, held[15:8]);
      held     = {held[7:0], b};
      byte_cnt = byte_cnt + 9'd1;
      case (phase)
        PhCmd: begin
          cmd_byte = b;
          phase    = PhLen;
        end
        PhLen: begin
          len_byte = b;
          phase    = PhBody;
        end
        default: begin
          frame_len = ((cmd_byte == LegacyCmd && legacy) ? {1'b0, LegacyPayload}
                                                          : {1'b0, len_byte}) + FrameOverhead;
          if (byte_cnt == frame_len) begin
            s.frame_end = 1'b1;
            s.crc_ok    = (held[15:8] == crc_acc[7:0]) && (held[7:0] == crc_acc[15:8]);
            phase       = PhHunt;
          end
        end
      endcase
    end
  endtask

  function automatic int field_diff(input string name, input logic [8:0] want,
                                    input logic [8:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    status_t want_s;
    status_t next_s;
    if (!rst_ni) begin
      dev_addr  = DevAddrReset;
      legacy    = 1'b0;
      phase     = PhHunt;
      byte_cnt  = '0;
      cmd_byte  = '0;
      len_byte  = '0;
      crc_acc   = CrcInit;
      held      = '0;
      pending_status.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) begin
        if (pending_status.size() == 0) begin
          $display("%0t: unexpected status word, echo %0d index %0d", $time,
                   out_mon.echo_byte, out_mon.byte_index);
          fail_count_o++;
        end else begin
          want_s = pending_status.pop_front();
          fail_count_o += field_diff("echo_byte", 9'(want_s.echo), 9'(out_mon.echo_byte));
          fail_count_o += field_diff("byte_index", want_s.index, out_mon.byte_index);
          fail_count_o += field_diff("accepted", 9'(want_s.accepted), 9'(out_mon.accepted));
          fail_count_o += field_diff("frame_end", 9'(want_s.frame_end), 9'(out_mon.frame_end));
          fail_count_o += field_diff("crc_ok", 9'(want_s.crc_ok), 9'(out_mon.crc_ok));
        end
      end
      if (cfg_mon.valid === 1'b1 && cfg_mon.ready === 1'b1) begin
        case (cfg_mon.addr)
          CfgDevAddr: dev_addr = cfg_mon.data;
          CfgLegacy:  legacy   = cfg_mon.data[0];
          default: ;
        endcase
      end
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1) begin
        // idle poll: back to hunting, no status word
        if (in_mon.cmd) begin
          phase = PhHunt;
        end else begin
          track_rx_byte(in_mon.rx_byte, next_s);
          pending_status.push_back(next_s);
        end
      end
      pending_o = pending_status.size();
    end
  end

endmodule

// ===== verif/modbus_frame_receiver_unit_test.sv =====
module modbus_frame_receiver_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mfr_pkg::*;

  localparam int unsigned BufSize      = 128;
  localparam int          ItemsTotal   = 1450;
  localparam int          NumPhases    = 6;
  localparam int          SettleCycles = 8;
  localparam int          Limit        = 400000;
  localparam logic        CmdByte      = 1'b0;
  localparam logic        CmdPoll      = 1'b1;

  logic       clk_i;
  logic       rst_ni;
  int         fail_count;
  int         pending;
  int         cycles = 0;
  int         words_sent = 0;
  logic [7:0] dev_addr_q = DevAddrReset;
  logic       legacy_q = 1'b0;
  bit         no_gaps = 1'b0;

  mfr_cfg_if cfg_if ();
  mfr_in_if  in_if ();
  mfr_out_if out_if ();

  modbus_frame_receiver_unit #(
    .BufSize(BufSize)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .in_i  (in_if),
    .out_o (out_if)
  );

  modbus_frame_receiver_unit_check #(
    .BufSize(BufSize)
  ) checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_mon     (cfg_if),
    .in_mon      (in_if),
    .out_mon     (out_if),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= Limit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // downstream stalls
  initial begin : out_stall
    int r;
    int n;
    logic v;
    out_if.ready = 1'b0;
    forever begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        v = 1'b1;
        n = $urandom_range(50, 150);
      end else if (r < 60) begin
        v = 1'b1;
        n = $urandom_range(1, 20);
      end else if (r < 92) begin
        v = 1'b0;
        n = $urandom_range(1, 3);
      end else begin
        v = 1'b0;
        n = $urandom_range(10, 40);
      end
      @(negedge clk_i);
      out_if.ready = v;
      repeat (n - 1) @(negedge clk_i);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] modbus_crc(input logic [7:0] msg[$]);
    logic [15:0] c;
    c = CrcInit;
    foreach (msg[i]) begin
      c = c ^ {8'h00, msg[i]};
      repeat (8) c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  task automatic put_word(input logic c, input logic [7:0] b);
    int gap;
    @(negedge clk_i);
    in_if.valid   = 1'b1;
    in_if.cmd     = c;
    in_if.rx_byte = b;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    words_sent++;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_if.valid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // hold the sender until every status word is back, then let the pipe drain
  task automatic settle();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgAddrW-1:0] a, input logic [CfgDataW-1:0] d);
    @(negedge clk_i);
    cfg_if.valid = 1'b1;
    cfg_if.addr  = a;
    cfg_if.data  = d;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  task automatic set_config(input logic [7:0] a, input logic l);
    settle();
    write_reg(CfgDevAddr, a);
    write_reg(CfgLegacy, CfgDataW'(l));
    dev_addr_q = a;
    legacy_q   = l;
  endtask

  task automatic send_frame(input logic [7:0] cmd_b, input logic [7:0] len_b,
                            input bit corrupt, input int keep);
    logic [7:0]  fr[$];
    logic [15:0] crc;
    int          body;
    int          pos;
    body = (legacy_q && cmd_b == LegacyCmd) ? int'(LegacyPayload) : int'(len_b);
    fr.push_back(dev_addr_q);
    fr.push_back(cmd_b);
    fr.push_back(len_b);
    repeat (body) fr.push_back(8'($urandom));
    crc = modbus_crc(fr);
    fr.push_back(crc[7:0]);
    fr.push_back(crc[15:8]);
    if (corrupt) begin
      pos = $urandom_range(3, fr.size() - 1);
      fr[pos] = fr[pos] ^ (8'h01 << $urandom_range(0, 7));
    end
    if (keep > 0) begin
      while (fr.size() > keep) void'(fr.pop_back());
    end
    foreach (fr[i]) put_word(CmdByte, fr[i]);
  endtask

  initial begin : stimulus
    logic [7:0] addr_set[NumPhases];
    logic       legacy_set[NumPhases];
    logic [7:0] cmd_b;
    logic [7:0] len_b;
    int         target;
    int         r;
    int         n;
    bit         pressured;

    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.cmd     = CmdByte;
    in_if.rx_byte = 8'h00;
    cfg_if.valid  = 1'b0;
    cfg_if.addr   = CfgDevAddr;
    cfg_if.data   = '0;
    pressured     = 1'b0;
    addr_set   = '{8'h00, 8'hFF, 8'($urandom), 8'h01, 8'($urandom), 8'($urandom)};
    legacy_set = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    set_config(DevAddrReset, 1'b0);
    put_word(CmdPoll, 8'hFF);
    put_word(CmdByte, 8'h00);
    put_word(CmdByte, 8'hFF);
    send_frame(8'h03, 8'd0, 1'b0, 0);
    send_frame(LegacyCmd, 8'd2, 1'b1, 0);
    send_frame(8'h10, 8'd4, 1'b0, 3);
    put_word(CmdPoll, 8'h00);
    send_frame(8'hFF, 8'd1, 1'b0, 0);
    set_config(8'hFF, 1'b1);
    send_frame(LegacyCmd, 8'd9, 1'b0, 0);

    for (int p = 0; p < NumPhases; p++) begin
      set_config(addr_set[p], legacy_set[p]);
      target = words_sent + ItemsTotal / NumPhases;
      while (words_sent < target) begin
        if ($urandom_range(0, 9) == 0) no_gaps = !no_gaps;
        if (p == 2 && !pressured && words_sent > target - 120) begin
          settle();
          pressured = 1'b1;
        end
        r = $urandom_range(0, 99);
        if (r < 70) begin
          cmd_b = ($urandom_range(0, 3) == 0) ? LegacyCmd : 8'($urandom);
          if ($urandom_range(0, 99) < 2) begin
            case ($urandom_range(0, 5))
              0:       len_b = 8'd122;
              1:       len_b = 8'd123;
              2:       len_b = 8'd124;
              3:       len_b = 8'd130;
              4:       len_b = 8'd200;
              default: len_b = 8'd255;
            endcase
          end else begin
            len_b = 8'($urandom_range(0, 12));
          end
          r = $urandom_range(0, 99);
          send_frame(cmd_b, len_b, r < 12, (r >= 12 && r < 22) ? $urandom_range(1, 4) : 0);
          if (r >= 12 && r < 22 && $urandom_range(0, 1) == 1) put_word(CmdPoll, 8'($urandom));
        end else if (r < 88) begin
          n = $urandom_range(1, 4);
          repeat (n) put_word(CmdByte, 8'($urandom));
          if ($urandom_range(0, 9) < 3) put_word(CmdPoll, 8'($urandom));
        end else begin
          put_word(CmdPoll, 8'($urandom));
        end
      end
    end

    no_gaps = 1'b0;
    settle();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
